FILE: rtl/kers_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kers_pkg
// Shared types, constants and record formatting for the key event record
// slot buffer.
// ----------------------------------------------------------------------------
package kers_pkg;

  localparam int SLOTS_DEFAULT = 8;

  localparam int KEY_W = 8;
  localparam int BYTE_W = 8;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_KEY_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPLOAD_TICK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TICKS = 2'd2;

  localparam logic [CFG_W-1:0] IDLE_KEY_CODE_RESET = 8'd0;
  localparam logic [CFG_W-1:0] UPLOAD_TICK_RESET = 8'd10;
  localparam logic [CFG_W-1:0] CYCLE_TICKS_RESET = 8'd20;

  localparam logic [7:0] SEQ_WRAP_LIMIT = 8'd200;
  localparam logic [7:0] SEQ_RESTART = 8'd1;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_D = 8'h44;
  localparam logic [7:0] ASCII_F = 8'h46;
  localparam logic [7:0] HEX_ALPHA_OFFSET = 8'h37;
  localparam logic [7:0] RECORD_TERMINATOR = 8'h00;

  localparam int RECORD_BYTES = 11;
  localparam int BYTE_IDX_W = 4;
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(RECORD_BYTES - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_UPLOAD = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
    logic [7:0] n;
    n = {4'd0, nibble};
    if (nibble >= 4'd10) begin
      return n + HEX_ALPHA_OFFSET;
    end
    return n + ASCII_ZERO;
  endfunction

  // byte layout: "00DDFF" seq(2 hex) key(2 hex) NUL
  function automatic logic [7:0] record_byte(input logic [BYTE_IDX_W-1:0] idx,
                                             input logic [7:0] seq,
                                             input logic [KEY_W-1:0] key);
    logic [7:0] b;
    unique case (idx)
      4'd0, 4'd1: b = ASCII_ZERO;
      4'd2, 4'd3: b = ASCII_D;
      4'd4, 4'd5: b = ASCII_F;
      4'd6:       b = hex_digit(seq[7:4]);
      4'd7:       b = hex_digit(seq[3:0]);
      4'd8:       b = hex_digit(key[7:4]);
      4'd9:       b = hex_digit(key[3:0]);
      default:    b = RECORD_TERMINATOR;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/kers_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kers_if
// Valid/ready channel interfaces for key events/ticks and record bytes.
// ----------------------------------------------------------------------------
interface kers_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] key_code;

  modport source(output valid, func, key_code, input ready);
  modport sink(input valid, func, key_code, output ready);
endinterface

interface kers_record_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       record_found;
  logic       last;

  modport source(output valid, out_byte, record_found, last, input ready);
  modport sink(input valid, out_byte, record_found, last, output ready);
endinterface

FILE: rtl/key_event_record_slot_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_record_slot_buffer
// Ring of key record slots with ticked upload of 11-byte ASCII records.
// ----------------------------------------------------------------------------
// Usage:
//   items channel: func=0 carries a key event (key_code), func=1 a loop tick.
//   records channel: each upload emits 11 transactions, "00DDFF", sequence
//   number in two hex digits, key code in two hex digits, then a zero byte;
//   last marks the eleventh byte, record_found tells if a slot was read.
//   Config port: cfg_we/cfg_index/cfg_data, write only while idle.
// Timing:
//   The front takes one item per cycle while the two-entry command queue
//   has room. The back walks the ring one slot per cycle: a store scans
//   from the write slot for a free slot; an upload scans from the read
//   slot for an occupied one, then emits the 11 record bytes through the
//   output register. Ticks that do not hit the upload count and idle-code
//   events end in the front and never reach the back. An uploading tick
//   goes through the queue, the idle state and the slot scan before the
//   first record byte is loaded into the output register.
// Reset (rst, synchronous): all slots free, pointers, sequence number and
//   tick counter zero, registers to their defaults.
// Stall: the record byte waits in the output register; the back holds, the
//   queue fills, then items.ready drops.
// ----------------------------------------------------------------------------
module key_event_record_slot_buffer #(
  parameter int SLOTS = kers_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  kers_item_if.sink                      items,
  kers_record_if.source                  records,
  input  logic                           cfg_we,
  input  logic [kers_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kers_pkg::CFG_W-1:0]     cfg_data
);

  logic           push;
  logic           push_ready;
  kers_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  kers_pkg::cmd_t pop_cmd;

  kers_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  kers_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  kers_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_ready (pop_ready),
    .records   (records)
  );

endmodule

FILE: rtl/kers_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kers_front
// Accepts input transactions, holds the configuration registers and the
// tick counter, and turns items into store/upload commands.
// ----------------------------------------------------------------------------
module kers_front (
  input  logic                                clk,
  input  logic                                rst,
  kers_item_if.sink                           items,
  input  logic                                cfg_we,
  input  logic [kers_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kers_pkg::CFG_W-1:0]          cfg_data,
  output logic                                push,
  output kers_pkg::cmd_t                      push_cmd,
  input  logic                                push_ready
);

  logic [7:0] idle_key_code;
  logic [7:0] upload_tick;
  logic [7:0] cycle_ticks;
  logic [7:0] tick_count;
  logic [7:0] tick_inc;
  logic       accept;
  logic       upload_hit;

  assign items.ready = push_ready;
  assign accept = items.valid && push_ready;
  assign tick_inc = tick_count + 8'd1;
  assign upload_hit = (tick_inc == upload_tick);

  always_comb begin
    push = 1'b0;
    push_cmd.op = kers_pkg::OP_STORE;
    push_cmd.key = items.key_code;
    if (accept) begin
      if (items.func) begin
        push = upload_hit;
        push_cmd.op = kers_pkg::OP_UPLOAD;
      end else begin
        push = (items.key_code != idle_key_code);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_key_code <= kers_pkg::IDLE_KEY_CODE_RESET;
      upload_tick <= kers_pkg::UPLOAD_TICK_RESET;
      cycle_ticks <= kers_pkg::CYCLE_TICKS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == kers_pkg::CFG_IDLE_KEY_CODE) begin
        idle_key_code <= cfg_data;
      end else if (cfg_index == kers_pkg::CFG_UPLOAD_TICK) begin
        upload_tick <= cfg_data;
      end else if (cfg_index == kers_pkg::CFG_CYCLE_TICKS) begin
        cycle_ticks <= cfg_data;
      end
    end
  end

  // upload match has priority over the cycle clear
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (accept && items.func) begin
      if (!upload_hit && tick_inc == cycle_ticks) begin
        tick_count <= '0;
      end else begin
        tick_count <= tick_inc;
      end
    end
  end

endmodule

FILE: rtl/kers_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kers_cmd_queue
// Two-entry command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module kers_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kers_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output kers_pkg::cmd_t pop_cmd,
  input  logic           pop_ready
);

  kers_pkg::cmd_t                     entries [kers_pkg::QUEUE_DEPTH];
  logic [kers_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [kers_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [kers_pkg::QUEUE_CNT_W-1:0]   count;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = (count != kers_pkg::QUEUE_CNT_W'(kers_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd = entries[rd_ptr];
  assign do_push = push && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/kers_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kers_back
// Slot ring: walks the ring one slot per cycle to store a key, or to find
// the next occupied slot and then stream the 11-byte record.
// ----------------------------------------------------------------------------
module kers_back #(
  parameter int SLOTS = kers_pkg::SLOTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  kers_pkg::cmd_t  cmd,
  output logic            cmd_ready,
  kers_record_if.source   records
);

  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STORE = 4'b0010,
    S_FIND  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                          state;
  logic [SLOTS-1:0]                slot_used;
  logic [kers_pkg::KEY_W-1:0]      slot_key [SLOTS];
  logic [PW-1:0]                   write_slot;
  logic [PW-1:0]                   read_slot;
  logic [PW-1:0]                   idx;
  logic [PW-1:0]                   step;
  logic [PW-1:0]                   idx_inc;
  logic [kers_pkg::KEY_W-1:0]      key_hold;
  logic [kers_pkg::KEY_W-1:0]      rd_key;
  logic                            found;
  logic [7:0]                      sequence_number;
  logic [7:0]                      seq_inc;
  logic [kers_pkg::BYTE_IDX_W-1:0] byte_idx;
  logic                            store_hit;
  logic                            find_hit;
  logic                            load_byte;
  logic [kers_pkg::KEY_W-1:0]      rec_key;

  function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  assign cmd_ready = (state == S_IDLE);
  assign idx_inc = slot_inc(idx);
  assign store_hit = (state == S_STORE) && !slot_used[idx];
  assign find_hit = (state == S_FIND) && slot_used[idx];
  assign load_byte = (state == S_EMIT) && (!records.valid || records.ready);
  assign seq_inc = sequence_number + 8'd1;
  assign rec_key = found ? rd_key : '0;

  // key store with registered read
  always_ff @(posedge clk) begin
    if (store_hit) begin
      slot_key[idx] <= key_hold;
    end
    if (find_hit) begin
      rd_key <= slot_key[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      key_hold <= cmd.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_used <= '0;
      write_slot <= '0;
      read_slot <= '0;
      sequence_number <= '0;
      idx <= '0;
      step <= '0;
      found <= 1'b0;
      byte_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            step <= '0;
            if (cmd.op == kers_pkg::OP_UPLOAD) begin
              idx <= read_slot;
              state <= S_FIND;
            end else begin
              idx <= write_slot;
              state <= S_STORE;
            end
          end
        end
        S_STORE: begin
          if (!slot_used[idx]) begin
            slot_used[idx] <= 1'b1;
            write_slot <= idx;
            state <= S_IDLE;
          end else if (step == LAST_SLOT) begin
            state <= S_IDLE;  // ring full, event dropped
          end else begin
            idx <= idx_inc;
            step <= step + 1'b1;
          end
        end
        S_FIND: begin
          byte_idx <= '0;
          if (slot_used[idx]) begin
            slot_used[idx] <= 1'b0;
            found <= 1'b1;
            read_slot <= idx_inc;
            state <= S_EMIT;
          end else if (step == LAST_SLOT) begin
            found <= 1'b0;
            read_slot <= slot_inc(read_slot);
            state <= S_EMIT;
          end else begin
            idx <= idx_inc;
            step <= step + 1'b1;
          end
        end
        S_EMIT: begin
          if (load_byte) begin
            if (byte_idx == kers_pkg::LAST_BYTE) begin
              sequence_number <= (seq_inc > kers_pkg::SEQ_WRAP_LIMIT) ?
                                 kers_pkg::SEQ_RESTART : seq_inc;
              state <= S_IDLE;
            end else begin
              byte_idx <= byte_idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      records.valid <= 1'b0;
    end else if (load_byte) begin
      records.valid <= 1'b1;
    end else if (records.ready) begin
      records.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      records.out_byte <= kers_pkg::record_byte(byte_idx, sequence_number, rec_key);
      records.record_found <= found;
      records.last <= (byte_idx == kers_pkg::LAST_BYTE);
    end
  end

endmodule
